### rtl/psft_pkg.sv
// Shared package for the phase-selectable FIR with threshold.
// Holds field widths, scaling constants, codes and word types.
// No dependencies; every other file but psft_stream_if imports it.
package psft_pkg;

    // Default sizes, handed to the top level parameters
    localparam int TAPS_DEF  = 64;
    localparam int BANKS_DEF = 8;

    // Field widths
    localparam int SAMPLE_W   = 8;
    localparam int LINE_W     = 9;
    localparam int COEF_W     = 24;
    localparam int BANK_W     = 3;
    localparam int INDEX_W    = 6;
    localparam int LEVEL_W    = 12;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int PROD_W     = COEF_W + LINE_W;

    // Level = floor(acc * 4095 / (255 * 2^20)) = floor(acc * 273 / (17 * 2^20))
    localparam int SCALE_NUM    = 273;
    localparam int SCALE_NUM_W  = 9;
    localparam int SCALE_SHIFT  = 20;
    localparam int SCALE_DEN    = 17;
    // Quotient before the divide by 17 saturates at 4096 * 17
    localparam int QUOT_W       = 17;
    localparam int QUOT_LIMIT   = 69632;
    // 3855 / 65536 is just under 1/17, the estimate is short by at most one
    localparam int RECIP_DEN    = 3855;
    localparam int RECIP_W      = 12;
    localparam int RECIP_SHIFT  = 16;
    localparam int EST_W        = QUOT_W + RECIP_W - RECIP_SHIFT;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 12'd4095;
    localparam logic [LEVEL_W-1:0] INTENSITY_LEVEL = 12'd400;

    // Input word commands
    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_LOAD   = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE  = 2'd0,
        CFG_THRESH = 2'd1,
        CFG_MODE   = 2'd2
    } t_cfg_idx;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic                       cmd;
        logic [SAMPLE_W-1:0]        sample;
        logic [BANK_W-1:0]          coef_bank;
        logic [INDEX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } t_in_word;

    typedef struct packed {
        logic [LEVEL_W-1:0] stim_level;
        logic               above_threshold;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
    } t_cfg_word;

    // Per-tap control that travels alongside the memory read data
    typedef struct packed {
        logic vld;
        logic zero;
        logic last;
    } t_tap_ctl;

    // Center a raw sample: x = 2*s - 255, exact in 9-bit two's complement
    function automatic logic signed [LINE_W-1:0] center(input logic [SAMPLE_W-1:0] s);
        logic [LINE_W-1:0] dbl;
        dbl = {s, 1'b0};
        return $signed(dbl - LINE_W'(255));
    endfunction

endpackage

### rtl/psft_stream_if.sv
// Valid/ready channel interface used for input, output and config words.
// Depends on nothing; the payload type is set where it is instantiated.
interface psft_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/psft_line_mem.sv
// Sample delay line held as a circular buffer in a synchronous memory.
// A fill count stands in for the all-zero reset. Uses psft_pkg.
module psft_line_mem import psft_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic signed [LINE_W-1:0] i_word,
    input  logic                     i_step,
    output logic signed [LINE_W-1:0] o_rd_data,
    output logic [$clog2(TAPS+1)-1:0] o_fill
);
    localparam int PTR_W  = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS+1);

    logic signed [LINE_W-1:0] r_mem [TAPS];
    logic signed [LINE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]         r_wr_ptr;
    logic [PTR_W-1:0]         r_rd_ptr;
    logic [FILL_W-1:0]        r_fill;
    logic [PTR_W-1:0]         n_wr_ptr;
    logic [PTR_W-1:0]         n_rd_dec;

    // Advance and retreat with wrap at the line depth
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(TAPS-1)) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_dec = (r_rd_ptr == '0) ? PTR_W'(TAPS-1) : r_rd_ptr - PTR_W'(1);
    end

    // Write the newest sample, read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_wr_ptr] <= i_word;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // Pointers and fill count; the read pointer restarts at the newest entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else if (i_push) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_wr_ptr;
            if (r_fill != FILL_W'(TAPS)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end else if (i_step) begin
            r_rd_ptr <= n_rd_dec;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill;
endmodule

### rtl/psft_coef_mem.sv
// Coefficient store: all banks in one synchronous memory, bank-major.
// One write port, one registered read port. Uses psft_pkg.
module psft_coef_mem import psft_pkg::*; #(
    parameter int DEPTH = TAPS_DEF * BANKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic signed [COEF_W-1:0]   i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic signed [COEF_W-1:0]   o_rdata
);
    logic signed [COEF_W-1:0] r_mem [DEPTH];
    logic signed [COEF_W-1:0] r_rdata;

    // Write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/psft_mac.sv
// Shared multiply-accumulate: one coefficient times one sample per cycle.
// Registered product, then accumulate. Uses psft_pkg.
module psft_mac import psft_pkg::*; #(
    parameter int ACC_W = PROD_W + $clog2(TAPS_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  t_tap_ctl                 i_ctl,
    input  logic signed [COEF_W-1:0] i_coef,
    input  logic signed [LINE_W-1:0] i_sample,
    output logic signed [ACC_W-1:0]  o_acc,
    output logic                     o_done
);
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    t_tap_ctl                 r_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    // Drop taps whose delay entry has not been filled since reset
    always_comb begin
        n_prod = PROD_W'(i_coef) * PROD_W'(i_sample);
        if (i_ctl.zero) begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.vld && r_ctl.last;
        end
    end

    // Accumulate; clear when a new filter word starts
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_ctl.vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;
endmodule

### rtl/psft_scale.sv
// Scales the accumulated sum to a 12-bit level and applies the threshold.
// Four register stages; divide by 17 by reciprocal plus one correction. Uses psft_pkg.
module psft_scale import psft_pkg::*; #(
    parameter int ACC_W = PROD_W + $clog2(TAPS_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ACC_W-1:0]  i_acc,
    input  logic [LEVEL_W-1:0]       i_thresh,
    input  logic                     i_mode,
    output t_out_word                o_res,
    output logic                     o_done
);
    localparam int POS_W = ACC_W - 1;
    localparam int P_W   = POS_W + SCALE_NUM_W;
    localparam int QF_W  = P_W - SCALE_SHIFT;
    localparam int RP_W  = QUOT_W + RECIP_W;

    logic [POS_W-1:0]  acc_pos;
    logic [P_W-1:0]    r_p;
    logic [QF_W-1:0]   quot_full;
    logic [QUOT_W-1:0] r_q;
    logic [QUOT_W-1:0] r_q3;
    logic              r_sat;
    logic              r_sat3;
    logic [RP_W-1:0]   recip_prod;
    logic [EST_W-1:0]  r_est;
    logic [QUOT_W-1:0] rem;
    logic [LEVEL_W-1:0] level;
    logic              above;
    t_out_word         n_res;
    t_out_word         r_res;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_done;

    // Stage 1: clamp negative sums to zero, multiply by 273
    assign acc_pos = i_acc[ACC_W-1] ? '0 : i_acc[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        r_p <= P_W'(acc_pos) * P_W'(SCALE_NUM);
    end

    // Stage 2: drop the 20 fraction bits, flag saturation
    assign quot_full = r_p[P_W-1:SCALE_SHIFT];

    always_ff @(posedge i_clk) begin
        r_sat <= (quot_full >= QF_W'(QUOT_LIMIT));
        r_q   <= quot_full[QUOT_W-1:0];
    end

    // Stage 3: estimate the quotient by 17
    assign recip_prod = RP_W'(r_q) * RP_W'(RECIP_DEN);

    always_ff @(posedge i_clk) begin
        r_est  <= recip_prod[RP_W-1:RECIP_SHIFT];
        r_q3   <= r_q;
        r_sat3 <= r_sat;
    end

    // Stage 4: correct the estimate, threshold and select the output
    always_comb begin
        rem   = r_q3 - QUOT_W'(QUOT_W'(r_est) * QUOT_W'(SCALE_DEN));
        level = r_est[LEVEL_W-1:0] + LEVEL_W'(rem >= QUOT_W'(SCALE_DEN));
        above = r_sat3 || (level > i_thresh);
        n_res.above_threshold = above;
        if (!above) begin
            n_res.stim_level = '0;
        end else if (i_mode) begin
            n_res.stim_level = INTENSITY_LEVEL;
        end else if (r_sat3) begin
            n_res.stim_level = LEVEL_MAX;
        end else begin
            n_res.stim_level = level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_res <= n_res;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
    end

    assign o_res  = r_res;
    assign o_done = r_done;
endmodule

### rtl/phase_selectable_fir_threshold.sv
// Phase-selectable FIR with threshold: top level.
// Depends on psft_pkg, psft_stream_if, psft_line_mem, psft_coef_mem, psft_mac, psft_scale.
//
// Usage:
//   i_in carries input words. cmd = load writes one coefficient into bank
//   coef_bank at tap coef_index (out-of-range loads are dropped) and gives
//   no result. cmd = filter centers the sample, shifts it into the delay
//   line and filters it with the bank chosen by phase_select; it gives one
//   result word on o_out (stim_level, above_threshold).
//   i_cfg writes phase_select (0), level_threshold (1), intensity_mode (2);
//   it is always ready. The user must see that it is written only while the
//   block is idle; the block itself does not enforce it. A load word is
//   taken while idle and leaves the block idle. A filter word keeps the
//   block busy through the tap walk, drain, scale and put states, and no new
//   word is accepted until its result is put. The single multiply-accumulate
//   reads one coefficient and one delay entry per cycle from the two memories.
//   Reset clears the configuration, the delay line fill count and all
//   control; coefficients are undefined until loaded.
//   If the receiver stalls, the result holds in the output register; the
//   block still accepts one more word and parks its result until the
//   output register frees.
module phase_selectable_fir_threshold import psft_pkg::*; #(
    parameter int TAPS  = TAPS_DEF,
    parameter int BANKS = BANKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psft_stream_if.sink    i_in,
    psft_stream_if.source  o_out,
    psft_stream_if.sink    i_cfg
);
    localparam int PTR_W   = $clog2(TAPS);
    localparam int FILL_W  = $clog2(TAPS+1);
    localparam int DEPTH   = BANKS * TAPS;
    localparam int CADDR_W = $clog2(DEPTH);
    localparam int ACC_W   = PROD_W + $clog2(TAPS);
    localparam int MOD_W   = 5;

    t_state                    r_state;
    t_state                    n_state;
    logic [PHASE_W-1:0]        r_phase;
    logic [LEVEL_W-1:0]        r_thresh;
    logic                      r_mode;
    logic                      in_ready;
    logic                      in_acc;
    logic                      filt_acc;
    logic                      load_acc;
    logic                      issue;
    logic                      put;
    logic [MOD_W-1:0]          bank_mod;
    logic [CADDR_W-1:0]        bank_base;
    logic                      ld_ok;
    logic [CADDR_W-1:0]        ld_addr;
    logic [PTR_W-1:0]          r_tap;
    logic [CADDR_W-1:0]        r_caddr;
    t_tap_ctl                  n_ctl;
    t_tap_ctl                  r_ctl;
    logic signed [LINE_W-1:0]  line_data;
    logic [FILL_W-1:0]         fill;
    logic signed [COEF_W-1:0]  coef_data;
    logic signed [ACC_W-1:0]   acc;
    logic                      mac_done;
    t_out_word                 scale_res;
    logic                      scale_done;
    logic                      r_out_vld;
    t_out_word                 r_out;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_thresh <= '0;
            r_mode   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.reg_index)
                CFG_PHASE:  r_phase  <= i_cfg.payload.reg_data[PHASE_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg.payload.reg_data[LEVEL_W-1:0];
                CFG_MODE:   r_mode   <= i_cfg.payload.reg_data[0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign in_acc   = i_in.valid && in_ready;
    assign filt_acc = in_acc && (i_in.payload.cmd == CMD_FILTER);
    assign load_acc = in_acc && (i_in.payload.cmd == CMD_LOAD);
    assign i_in.ready = in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (filt_acc) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_tap == PTR_W'(TAPS-1)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (mac_done) n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (scale_done) n_state = ST_PUT;
            end
            ST_PUT: begin
                if (!r_out_vld || o_out.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        put      = 1'b0;
        case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_RUN:  issue    = 1'b1;
            ST_PUT:  put      = !r_out_vld || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Reduce the phase to a bank and find its base address
    always_comb begin
        bank_mod = MOD_W'(r_phase);
        for (int k = 0; k < 8; k++) begin
            if (bank_mod >= MOD_W'(BANKS)) begin
                bank_mod = bank_mod - MOD_W'(BANKS);
            end
        end
        bank_base = CADDR_W'(CADDR_W'(bank_mod) * CADDR_W'(TAPS));
    end

    // Coefficient load address; drop out-of-range loads
    always_comb begin
        ld_ok   = (32'(i_in.payload.coef_bank) < BANKS) &&
                  (32'(i_in.payload.coef_index) < TAPS);
        ld_addr = CADDR_W'(CADDR_W'(i_in.payload.coef_bank) * CADDR_W'(TAPS)) +
                  CADDR_W'(i_in.payload.coef_index);
    end

    // Tap walk: one coefficient and one delay entry per cycle
    always_ff @(posedge i_clk) begin
        if (filt_acc) begin
            r_tap   <= '0;
            r_caddr <= bank_base;
        end else if (issue) begin
            r_tap   <= r_tap + PTR_W'(1);
            r_caddr <= r_caddr + CADDR_W'(1);
        end
    end

    // Tap control lines up with the registered memory reads
    always_comb begin
        n_ctl.vld  = issue;
        n_ctl.zero = (FILL_W'(r_tap) >= fill);
        n_ctl.last = (r_tap == PTR_W'(TAPS-1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    psft_line_mem #(.TAPS(TAPS)) u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (filt_acc),
        .i_word    (center(i_in.payload.sample)),
        .i_step    (issue),
        .o_rd_data (line_data),
        .o_fill    (fill)
    );

    psft_coef_mem #(.DEPTH(DEPTH)) u_coef (
        .i_clk   (i_clk),
        .i_we    (load_acc && ld_ok),
        .i_waddr (ld_addr),
        .i_wdata (i_in.payload.coef_value),
        .i_raddr (r_caddr),
        .o_rdata (coef_data)
    );

    psft_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (filt_acc),
        .i_ctl    (r_ctl),
        .i_coef   (coef_data),
        .i_sample (line_data),
        .o_acc    (acc),
        .o_done   (mac_done)
    );

    psft_scale #(.ACC_W(ACC_W)) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_done),
        .i_acc    (acc),
        .i_thresh (r_thresh),
        .i_mode   (r_mode),
        .o_res    (scale_res),
        .o_done   (scale_done)
    );

    // Output register: hold the word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (put) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (put) begin
            r_out <= scale_res;
        end
    end

    assign o_out.valid   = r_out_vld;
    assign o_out.payload = r_out;
endmodule

### rtl/psft_checker.sv
// Port-level checks for the phase-selectable FIR with threshold.
// Uses psft_pkg; bound to phase_selectable_fir_threshold below.
module psft_checker import psft_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_in_cmd,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_word
);
    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A filter word keeps the block busy
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_FILTER) |=> !i_in_ready)
        else $error("input ready right after a filter word");

    // A new result only comes out of the busy phase
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while idle");

    // A nonzero level implies the threshold was exceeded
    a_level_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.stim_level != '0) |-> i_out_word.above_threshold)
        else $error("nonzero level without above_threshold");
endmodule

bind phase_selectable_fir_threshold psft_checker u_psft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.payload.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.payload)
);

### tb/sv/tb.sv
// Self-checking bench for phase_selectable_fir_threshold: FIR plus threshold over
// valid/ready words, checked against an in-bench fixed-point predictor.
// Depends on psft_pkg, psft_stream_if and the top level RTL.
module tb;
    import psft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PHASES         = 9;
    localparam int     PHASE_ITEMS    = 24;
    localparam int     SETTLE_CYCLES  = TAPS_DEF + 32;
    localparam int     DRAIN_LIMIT    = 5000;
    localparam int     RX_HOLD_CYCLES = 600;
    localparam longint DAC_FULL       = 4095;
    localparam longint ACC_FULL       = 255 * (2 ** 20);
    localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sh100000;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;

    typedef struct packed {
        t_in_word  word;
        logic      typed;
        t_out_word result;
    } t_row;

    // Directed words; typed results hold only while tap 0 is the only bank 0 tap with a nonzero product
    localparam int DIRECTED_COUNT = 19;
    localparam t_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{CMD_FILTER, 8'd128, 3'd0, 6'd0,  24'sd0},        1'b1, '{12'd16,   1'b1}},
        '{'{CMD_FILTER, 8'd255, 3'd0, 6'd0,  24'sd0},        1'b1, '{12'd4095, 1'b1}},
        '{'{CMD_FILTER, 8'd0,   3'd0, 6'd0,  24'sd0},        1'b1, '{12'd0,    1'b0}},
        '{'{CMD_FILTER, 8'd127, 3'd0, 6'd0,  24'sd0},        1'b1, '{12'd0,    1'b0}},
        '{'{CMD_FILTER, 8'd129, 3'd0, 6'd0,  24'sd0},        1'b1, '{12'd48,   1'b1}},
        '{'{CMD_FILTER, 8'd254, 3'd0, 6'd0,  24'sd0},        1'b0, '{12'd0,    1'b0}},
        '{'{CMD_LOAD,   8'd0,   3'd0, 6'd0,  24'sh7FFFFF},   1'b0, '{12'd0,    1'b0}},
        '{'{CMD_FILTER, 8'd255, 3'd0, 6'd0,  24'sd0},        1'b1, '{12'd4095, 1'b1}},
        '{'{CMD_FILTER, 8'd128, 3'd0, 6'd0,  24'sd0},        1'b0, '{12'd0,    1'b0}},
        '{'{CMD_LOAD,   8'd255, 3'd0, 6'd0,  24'sh800000},   1'b0, '{12'd0,    1'b0}},
        '{'{CMD_FILTER, 8'd255, 3'd0, 6'd0,  24'sd0},        1'b1, '{12'd0,    1'b0}},
        '{'{CMD_FILTER, 8'd0,   3'd0, 6'd0,  24'sd0},        1'b1, '{12'd4095, 1'b1}},
        '{'{CMD_LOAD,   8'd0,   3'd7, 6'd63, 24'sh7FFFFF},   1'b0, '{12'd0,    1'b0}},
        '{'{CMD_LOAD,   8'd0,   3'd0, 6'd63, 24'sh800000},   1'b0, '{12'd0,    1'b0}},
        '{'{CMD_LOAD,   8'd0,   3'd7, 6'd0,  24'shFFFFFF},   1'b0, '{12'd0,    1'b0}},
        '{'{CMD_LOAD,   8'd0,   3'd0, 6'd0,  24'sh100000},   1'b0, '{12'd0,    1'b0}},
        '{'{CMD_FILTER, 8'd130, 3'd0, 6'd0,  24'sd0},        1'b1, '{12'd80,   1'b1}},
        '{'{CMD_FILTER, 8'd200, 3'd0, 6'd0,  24'sd0},        1'b0, '{12'd0,    1'b0}},
        '{'{CMD_FILTER, 8'd1,   3'd0, 6'd0,  24'sd0},        1'b0, '{12'd0,    1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    psft_stream_if #(.T(t_in_word))  in_if  ();
    psft_stream_if #(.T(t_out_word)) out_if ();
    psft_stream_if #(.T(t_cfg_word)) cfg_if ();

    phase_selectable_fir_threshold #(
        .TAPS  (TAPS_DEF),
        .BANKS (BANKS_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: delay line, coefficient banks and register copies
    logic signed [LINE_W-1:0] tap_line [TAPS_DEF];
    logic signed [COEF_W-1:0] coef_mem [BANKS_DEF * TAPS_DEF];
    logic [PHASE_W-1:0]       cur_phase;
    logic [LEVEL_W-1:0]       cur_threshold;
    logic                     cur_intensity;

    t_out_word pending_levels [$];
    int        error_count = 0;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        rx_hold_cnt = 0;
    bit        rx_hold_req = 1'b0;

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shift one centered sample in, convolve with the selected bank, threshold the level
    function automatic t_out_word filter_sample(input logic [SAMPLE_W-1:0] s);
        longint    acc;
        longint    lvl;
        int        base;
        t_out_word r;
        for (int j = TAPS_DEF - 1; j > 0; j--) tap_line[j] = tap_line[j-1];
        tap_line[0] = LINE_W'(2 * int'(s) - 255);
        base = (cur_phase % BANKS_DEF) * TAPS_DEF;
        acc = 0;
        for (int j = 0; j < TAPS_DEF; j++) begin
            acc += longint'(coef_mem[base + j]) * longint'(tap_line[j]);
        end
        lvl = (acc < 0) ? 0 : (acc * DAC_FULL) / ACC_FULL;
        r = '0;
        // Compare before saturation, then pick level or fixed intensity
        if (lvl > longint'(cur_threshold)) begin
            r.above_threshold = 1'b1;
            if (cur_intensity)
                r.stim_level = INTENSITY_LEVEL;
            else
                r.stim_level = (lvl >= DAC_FULL) ? LEVEL_MAX : LEVEL_W'(lvl);
        end
        return r;
    endfunction

    // Offer one input word after a random gap; predict once it is taken
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_result);
        t_out_word predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= w;
        do @(posedge i_clk); while (!in_if.ready);
        if (w.cmd == CMD_LOAD) begin
            // Drop loads outside the store
            if (w.coef_bank < BANKS_DEF && w.coef_index < TAPS_DEF)
                coef_mem[w.coef_bank * TAPS_DEF + w.coef_index] = w.coef_value;
        end else begin
            predicted = filter_sample(w.sample);
            pending_levels.push_back(typed ? typed_result : predicted);
        end
        @(negedge i_clk);
    endtask

    // Write all three registers; the block must be idle
    task automatic set_config(input logic [PHASE_W-1:0] ph, input logic [LEVEL_W-1:0] thr,
                              input logic mode);
        t_cfg_word regs_out [3];
        regs_out[0] = '{CFG_PHASE,  CFG_DATA_W'(ph)};
        regs_out[1] = '{CFG_THRESH, CFG_DATA_W'(thr)};
        regs_out[2] = '{CFG_MODE,   CFG_DATA_W'(mode)};
        for (int k = 0; k < 3; k++) begin
            cfg_if.valid   <= 1'b1;
            cfg_if.payload <= regs_out[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            case (t_cfg_idx'(regs_out[k].reg_index))
                CFG_PHASE:  cur_phase     = regs_out[k].reg_data[PHASE_W-1:0];
                CFG_THRESH: cur_threshold = regs_out[k].reg_data[LEVEL_W-1:0];
                CFG_MODE:   cur_intensity = regs_out[k].reg_data[0];
                default: ;
            endcase
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every pending result, bounded; optionally let trailing load words settle
    task automatic wait_results(input bit settle);
        int waited;
        waited = 0;
        while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (settle) repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Result receiver: random stalls, plus one long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt = rx_hold_cnt - 1;
            out_if.ready <= 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_cnt = RX_HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check each result word against the oldest pending level
    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (pending_levels.size() == 0) begin
                $error("unexpected result word: stim_level %0d above_threshold %0d",
                       got.stim_level, got.above_threshold);
                error_count++;
            end else begin
                want = pending_levels.pop_front();
                if (got.stim_level !== want.stim_level) begin
                    $error("stim_level mismatch: expected %0d, got %0d",
                           want.stim_level, got.stim_level);
                    error_count++;
                end
                if (got.above_threshold !== want.above_threshold) begin
                    $error("above_threshold mismatch: expected %0d, got %0d",
                           want.above_threshold, got.above_threshold);
                    error_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_in_word           word;
        logic [PHASE_W-1:0] ph;
        logic [LEVEL_W-1:0] thr;
        int                 pick;

        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        out_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        cur_phase      = '0;
        cur_threshold  = '0;
        cur_intensity  = 1'b0;
        foreach (tap_line[j]) tap_line[j] = '0;
        foreach (coef_mem[j]) coef_mem[j] = '0;
        tx_idle_pct = 25;
        rx_idle_pct = 47;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_config(3'd0, 12'd0, 1'b0);

        // Fill every bank so no unwritten entry is ever read
        for (int b = 0; b < BANKS_DEF; b++) begin
            for (int t = 0; t < TAPS_DEF; t++) begin
                word            = t_in_word'($bits(t_in_word)'({$urandom, $urandom}));
                word.cmd        = CMD_LOAD;
                word.coef_bank  = BANK_W'(b);
                word.coef_index = INDEX_W'(t);
                case (b)
                    0: word.coef_value = (t == 0) ? COEF_ONE : '0;
                    1: word.coef_value = COEF_W'(int'($urandom_range(131071)) - 65536);
                    2: word.coef_value = COEF_W'($urandom);
                    3: word.coef_value = '0;
                    4: word.coef_value = COEF_MAX;
                    5: word.coef_value = COEF_MIN;
                    6: word.coef_value = COEF_W'(COEF_ONE / TAPS_DEF);
                    default: word.coef_value = COEF_W'(int'($urandom_range(524287)) - 262144);
                endcase
                send_word(word, 1'b0, '0);
            end
        end

        // Walk the directed table
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            in_if.valid <= 1'b0;
            wait_results(1'b1);
            @(posedge i_clk);
            tx_idle_pct = (p < 3) ? 25 : (p < 6) ? 47 : 0;
            rx_idle_pct = (p < 3) ? 47 : (p < 6) ? 25 : 0;
            if (p == 1) rx_hold_req = 1'b1;
            @(negedge i_clk);
            case (p)
                0: begin ph = 3'd0; thr = 12'd0; end
                1: begin ph = 3'd1; thr = LEVEL_MAX; end
                2: begin ph = 3'd2; thr = LEVEL_W'($urandom_range(4095)); end
                3: begin ph = 3'd3; thr = 12'd0; end
                4: begin ph = 3'd4; thr = LEVEL_W'($urandom_range(4095)); end
                5: begin ph = 3'd5; thr = LEVEL_W'($urandom_range(300)); end
                6: begin ph = 3'd6; thr = LEVEL_W'($urandom_range(4095)); end
                7: begin ph = 3'd7; thr = 12'd2000; end
                default: begin
                    ph  = PHASE_W'($urandom_range(7));
                    thr = LEVEL_W'($urandom_range(4095));
                end
            endcase
            set_config(ph, thr, (p % 3) == 2);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Hold the sender once until every result is back
                if (p == 4 && i == PHASE_ITEMS / 2) begin
                    in_if.valid <= 1'b0;
                    @(negedge i_clk);
                    wait_results(1'b0);
                end
                word = t_in_word'($bits(t_in_word)'({$urandom, $urandom}));
                if ($urandom_range(15) == 0) word.sample = $urandom_range(1) ? 8'hFF : 8'h00;
                word.cmd = ($urandom_range(99) < 22) ? CMD_LOAD : CMD_FILTER;
                if (word.cmd == CMD_LOAD && $urandom_range(1)) word.coef_bank = ph;
                // Spread coefficient magnitudes: full range, extremes, small, medium
                pick = $urandom_range(99);
                if (pick < 10)
                    word.coef_value = COEF_W'($urandom);
                else if (pick < 16)
                    word.coef_value = $urandom_range(1) ? COEF_MAX : COEF_MIN;
                else if (pick < 60)
                    word.coef_value = COEF_W'(int'($urandom_range(131071)) - 65536);
                else
                    word.coef_value = COEF_W'(int'($urandom_range(1048575)) - 524288);
                send_word(word, 1'b0, '0);
            end
        end

        // Drain and report
        in_if.valid <= 1'b0;
        wait_results(1'b1);
        if (pending_levels.size() != 0) begin
            $error("%0d expected result words never arrived", pending_levels.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("phase_selectable_fir_threshold verification clean");
        end else begin
            $display("phase_selectable_fir_threshold verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("phase_selectable_fir_threshold verification failed");
        $finish;
    end

endmodule
